// ===== rtl/tfm_pkg.sv =====
`timescale 1ns / 1ps

package tfm_pkg;

	// Wildcard and separator characters of a topic filter.
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Meaning of the mode field of an input beat.
	localparam logic MODE_FILTER = 1'b0;
	localparam logic MODE_TOPIC  = 1'b1;

	// One result beat.
	typedef struct packed {
		logic matched;
		logic filter_overflow;
	} tfm_result_t;

endpackage

// ===== rtl/topic_filter_matcher_top.sv =====
`timescale 1ns / 1ps

// Topic filter matcher: one input beat (filter byte or topic byte) per cycle while item_stall is low.
// The result of a topic is registered in the output register, or in the skid stage if the output is held.
// The filter memory's two read ports prefetch the bytes at filter position +2 and +3
// so that one topic byte can step the position by up to two.
// Reset clears lengths, flags and handshake state; the filter memory is not cleared.
module topic_filter_matcher_top #(
	parameter int FILTER_MAX_LEN = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic                mode,
	input  logic [7:0]          char_in,
	input  logic                last_char,
	output logic                res_valid,
	input  logic                res_stall,
	output logic                matched,
	output logic                filter_overflow
);
	import tfm_pkg::*;

	localparam int AW = (FILTER_MAX_LEN > 1) ? $clog2(FILTER_MAX_LEN) : 1;
	localparam int LW = $clog2(FILTER_MAX_LEN + 1);
	localparam logic [LW-1:0] MAX_LEN = LW'(FILTER_MAX_LEN);

	// Filter store and the read data of its two ports.
	logic [7:0] filter_mem [FILTER_MAX_LEN];
	logic [7:0] rd2_q, rd3_q;
	logic       fwd2_q, fwd3_q;
	logic [7:0] fwd_data_q;

	// Load and match state.
	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic          closed_q;
	logic [LW-1:0] pos_q;
	logic          skip_q;
	logic          mis_q;
	logic          hash_q;

	// Filter bytes at the current position and the next one, and the filter head.
	logic [7:0] w0_q, w1_q;
	logic [7:0] head0_q, head1_q;

	// Output register and skid stage.
	logic        res_valid_q;
	tfm_result_t res_q;
	logic        skid_valid_q;
	tfm_result_t skid_q;

	logic          item_fire;
	logic          filter_beat;
	logic          topic_beat;
	logic          res_new;
	tfm_result_t   res_data;
	logic [7:0]    bw [4];
	logic          v0, v1;
	logic [1:0]    step;
	logic          nskip, nmis, nhash;
	logic [LW-1:0] npos;
	logic [LW-1:0] rest;
	logic [7:0]    nb0, nb1;
	logic [LW-1:0] eff_len;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [LW-1:0] pos_next;
	logic [AW-1:0] rd_addr2, rd_addr3;

	assign item_stall  = skid_valid_q;
	assign item_fire   = item_valid && !item_stall;
	assign filter_beat = item_fire && (mode == MODE_FILTER);
	assign topic_beat  = item_fire && (mode == MODE_TOPIC);
	assign res_new     = topic_beat && last_char;

	// Window of four filter bytes starting at the current position.
	always_comb begin
		bw[0] = w0_q;
		bw[1] = w1_q;
		bw[2] = fwd2_q ? fwd_data_q : rd2_q;
		bw[3] = fwd3_q ? fwd_data_q : rd3_q;
	end

	assign v0 = ({1'b0, pos_q} < {1'b0, len_q});
	assign v1 = ({1'b0, pos_q} + (LW+1)'(1) < {1'b0, len_q});

	// One topic byte against the filter: the position moves by zero, one or two.
	always_comb begin
		step  = 2'd0;
		nskip = skip_q;
		nmis  = mis_q;
		nhash = hash_q;
		if (!mis_q && !hash_q) begin
			if (skip_q) begin
				if (char_in == CH_SLASH) begin
					nskip = 1'b0;
					if (v0 && bw[0] == CH_SLASH) begin
						step = 2'd1;
					end else begin
						nmis = 1'b1;
					end
				end
			end else if (!v0) begin
				nmis = 1'b1;
			end else if (bw[0] == CH_HASH) begin
				nhash = 1'b1;
			end else if (bw[0] == CH_PLUS) begin
				step = 2'd1;
				if (char_in == CH_SLASH) begin
					if (v1 && bw[1] == CH_SLASH) begin
						step = 2'd2;
					end else begin
						nmis = 1'b1;
					end
				end else begin
					nskip = 1'b1;
				end
			end else if (bw[0] == char_in) begin
				step = 2'd1;
			end else begin
				nmis = 1'b1;
			end
		end
	end

	// Result of a topic that ends on this byte; a trailing "#" or "/#" still matches.
	always_comb begin
		npos = pos_q + LW'(step);
		rest = len_q - npos;
		nb0  = bw[step];
		nb1  = bw[step + 2'd1];
		res_data.filter_overflow = ovf_q;
		res_data.matched = !ovf_q && !nmis &&
			(nhash || (rest == '0) ||
			 ((rest == LW'(1)) && !nskip && (nb0 == CH_HASH)) ||
			 ((rest == LW'(2)) && (nb0 == CH_SLASH) && (nb1 == CH_HASH)));
	end

	// A filter byte after a closed filter starts a new one.
	assign eff_len = closed_q ? '0 : len_q;
	assign wr_en   = filter_beat && (eff_len < MAX_LEN);
	assign wr_addr = eff_len[AW-1:0];

	// Position after this cycle, which addresses the prefetch reads.
	always_comb begin
		pos_next = pos_q;
		if (filter_beat || res_new) begin
			pos_next = '0;
		end else if (topic_beat) begin
			pos_next = npos;
		end
	end

	assign rd_addr2 = AW'(pos_next + LW'(2));
	assign rd_addr3 = AW'(pos_next + LW'(3));

	// Filter memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			filter_mem[wr_addr] <= char_in;
		end
		rd2_q <= filter_mem[rd_addr2];
		rd3_q <= filter_mem[rd_addr3];
	end

	// Forward a write that lands on an address read in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd2_q <= 1'b0;
			fwd3_q <= 1'b0;
		end else begin
			fwd2_q <= wr_en && (wr_addr == rd_addr2);
			fwd3_q <= wr_en && (wr_addr == rd_addr3);
		end
	end

	// Window and head bytes.
	always_ff @(posedge clk) begin
		fwd_data_q <= char_in;
		if (wr_en && eff_len == '0) begin
			head0_q <= char_in;
		end
		if (wr_en && eff_len == LW'(1)) begin
			head1_q <= char_in;
		end
		if (filter_beat) begin
			w0_q <= (wr_en && eff_len == '0) ? char_in : head0_q;
			w1_q <= (wr_en && eff_len == LW'(1)) ? char_in : head1_q;
		end else if (res_new) begin
			w0_q <= head0_q;
			w1_q <= head1_q;
		end else if (topic_beat) begin
			w0_q <= nb0;
			w1_q <= nb1;
		end
	end

	// Load and match state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			ovf_q    <= 1'b0;
			closed_q <= 1'b0;
			pos_q    <= '0;
			skip_q   <= 1'b0;
			mis_q    <= 1'b0;
			hash_q   <= 1'b0;
		end else begin
			pos_q <= pos_next;
			if (filter_beat) begin
				if (wr_en) begin
					len_q <= eff_len + LW'(1);
					ovf_q <= closed_q ? 1'b0 : ovf_q;
				end else begin
					len_q <= eff_len;
					ovf_q <= 1'b1;
				end
				closed_q <= last_char;
				skip_q   <= 1'b0;
				mis_q    <= 1'b0;
				hash_q   <= 1'b0;
			end else if (topic_beat) begin
				closed_q <= 1'b1;
				skip_q   <= res_new ? 1'b0 : nskip;
				mis_q    <= res_new ? 1'b0 : nmis;
				hash_q   <= res_new ? 1'b0 : nhash;
			end
		end
	end

	// Output register with a skid stage behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!res_valid_q || !res_stall) begin
			res_valid_q  <= skid_valid_q || res_new;
			skid_valid_q <= 1'b0;
		end else if (res_new) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || !res_stall) begin
			res_q <= skid_valid_q ? skid_q : res_data;
		end else if (res_new) begin
			skid_q <= res_data;
		end
	end

	assign res_valid       = res_valid_q;
	assign matched         = res_q.matched;
	assign filter_overflow = res_q.filter_overflow;

	// The compare position never runs past the loaded filter.
	a_pos_in_filter: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= len_q) else $error("filter position beyond filter length");

	// Overflow is only flagged once the store is full.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (len_q == MAX_LEN)) else $error("overflow with store not full");

	// A waiting skid beat always sits behind a held output beat.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q) else $error("skid full with output empty");

	// An overflowed filter never reports a match.
	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.filter_overflow) |-> !res_q.matched)
		else $error("match reported on overflowed filter");

	// A reached '#' and a level skip exclude each other.
	a_hash_skip: assert property (@(posedge clk) disable iff (!arst_n)
		!(hash_q && skip_q)) else $error("hash and level skip both set");

endmodule

// ===== verif/tfm_match_checker.sv =====
`timescale 1ns / 1ps

module tfm_match_checker #(
	parameter int FILTER_MAX_LEN = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_stall,
	input  logic       mode,
	input  logic [7:0] char_in,
	input  logic       last_char,
	input  logic       res_valid,
	input  logic       res_stall,
	input  logic       matched,
	input  logic       filter_overflow,
	output int         fail_count,
	output int         pending
);

	import tfm_pkg::*;

	localparam int LW = $clog2(FILTER_MAX_LEN + 1) + 1;

	// Shadow copy of the filter store and the match tracking state.
	logic [7:0]    fstore [int];
	logic [LW-1:0] flen;
	logic [LW-1:0] fpos;
	logic          ovf;
	logic          closed;
	logic          skipping;
	logic          missed;
	logic          hashed;

	// Verdicts predicted for topics whose last byte has been taken.
	tfm_result_t   verdict_q [$];

	// True when the loaded filter holds character ch at position pos.
	function automatic logic filter_has(int pos, logic [7:0] ch);
		if (pos >= int'(flen))
			return 1'b0;
		return fstore[pos] == ch;
	endfunction

	task automatic clear_topic();
		fpos     = '0;
		skipping = 1'b0;
		missed   = 1'b0;
		hashed   = 1'b0;
	endtask

	// A filter byte either starts a new filter or extends the open one.
	task automatic take_filter_byte(input logic [7:0] c, input logic lst);
		if (closed) begin
			flen   = '0;
			ovf    = 1'b0;
			closed = 1'b0;
		end
		if (int'(flen) < FILTER_MAX_LEN) begin
			fstore[int'(flen)] = c;
			flen++;
		end else begin
			ovf = 1'b1;
		end
		if (lst)
			closed = 1'b1;
		clear_topic();
	endtask

	// Advance the filter position over one topic byte.
	task automatic take_topic_byte(input logic [7:0] c);
		if (missed || hashed)
			return;
		if (skipping) begin
			if (c == CH_SLASH) begin
				skipping = 1'b0;
				if (filter_has(int'(fpos), CH_SLASH))
					fpos++;
				else
					missed = 1'b1;
			end
			return;
		end
		if (fpos >= flen) begin
			missed = 1'b1;
			return;
		end
		if (fstore[int'(fpos)] == CH_HASH) begin
			hashed = 1'b1;
		end else if (fstore[int'(fpos)] == CH_PLUS) begin
			fpos++;
			if (c == CH_SLASH) begin
				if (filter_has(int'(fpos), CH_SLASH))
					fpos++;
				else
					missed = 1'b1;
			end else begin
				skipping = 1'b1;
			end
		end else if (fstore[int'(fpos)] == c) begin
			fpos++;
		end else begin
			missed = 1'b1;
		end
	endtask

	// Decide the match once the topic has ended; a trailing "#" or "/#" still matches.
	function automatic logic topic_matches();
		int rest;
		if (ovf || missed)
			return 1'b0;
		if (hashed)
			return 1'b1;
		rest = int'(flen) - int'(fpos);
		if (rest <= 0)
			return 1'b1;
		if (rest == 1 && !skipping && filter_has(int'(fpos), CH_HASH))
			return 1'b1;
		if (rest == 2 && filter_has(int'(fpos), CH_SLASH)
				&& filter_has(int'(fpos) + 1, CH_HASH))
			return 1'b1;
		return 1'b0;
	endfunction

	// Compare result beats against predictions, then predict from the input beat.
	always @(posedge clk or negedge arst_n) begin
		tfm_result_t seen;
		tfm_result_t want;
		if (!arst_n) begin
			flen       = '0;
			ovf        = 1'b0;
			closed     = 1'b0;
			clear_topic();
			verdict_q.delete();
			fail_count = 0;
		end else begin
			if (res_valid && !res_stall) begin
				seen.matched         = matched;
				seen.filter_overflow = filter_overflow;
				if (verdict_q.size() == 0) begin
					$display("%0t: result beat with nothing predicted (matched %0b, overflow %0b)",
						$time, seen.matched, seen.filter_overflow);
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					if (seen.matched !== want.matched) begin
						$display("%0t: matched expected %0b actual %0b",
							$time, want.matched, seen.matched);
						fail_count++;
					end
					if (seen.filter_overflow !== want.filter_overflow) begin
						$display("%0t: filter_overflow expected %0b actual %0b",
							$time, want.filter_overflow, seen.filter_overflow);
						fail_count++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				if (mode == MODE_FILTER) begin
					take_filter_byte(char_in, last_char);
				end else begin
					closed = 1'b1;
					take_topic_byte(char_in);
					if (last_char) begin
						want.matched         = topic_matches();
						want.filter_overflow = ovf;
						verdict_q.push_back(want);
						clear_topic();
					end
				end
			end
		end
		pending = verdict_q.size();
	end

endmodule

// ===== verif/tb_topic_filter_matcher_top.sv =====
`timescale 1ns / 1ps

module tb_topic_filter_matcher_top;

	import tfm_pkg::*;

	localparam int FILTER_MAX_LEN = 64;
	localparam int ITEM_TARGET    = 1250;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	logic       mode;
	logic [7:0] char_in;
	logic       last_char;
	logic       res_valid;
	logic       res_stall;
	logic       matched;
	logic       filter_overflow;
	int         fail_count;
	int         pending;

	logic       quiet;
	int         sent;
	logic [7:0] filt_bytes [$];
	logic [7:0] topic_bytes [$];

	topic_filter_matcher_top #(
		.FILTER_MAX_LEN(FILTER_MAX_LEN)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.mode           (mode),
		.char_in        (char_in),
		.last_char      (last_char),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.matched        (matched),
		.filter_overflow(filter_overflow)
	);

	tfm_match_checker #(
		.FILTER_MAX_LEN(FILTER_MAX_LEN)
	) match_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.mode           (mode),
		.char_in        (char_in),
		.last_char      (last_char),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.matched        (matched),
		.filter_overflow(filter_overflow),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side stalls about a quarter of the time, except in the quiet stretch.
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			res_stall <= !quiet && ($urandom_range(0, 99) < 25);
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#2ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Present one input beat, with a random gap first, and hold it until taken.
	task automatic send_beat(input logic m, input logic [7:0] c, input logic lst);
		if (!quiet) begin
			while ($urandom_range(0, 99) < 25) begin
				item_valid <= 1'b0;
				@(negedge clk);
			end
		end
		item_valid <= 1'b1;
		mode       <= m;
		char_in    <= c;
		last_char  <= lst;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_text(input logic m, input string s, input logic close);
		for (int i = 0; i < s.len(); i++)
			send_beat(m, s[i], close && (i == s.len() - 1));
	endtask

	task automatic send_filter(input logic close);
		foreach (filt_bytes[i])
			send_beat(MODE_FILTER, filt_bytes[i], close && (i == filt_bytes.size() - 1));
	endtask

	task automatic send_topic();
		foreach (topic_bytes[i])
			send_beat(MODE_TOPIC, topic_bytes[i], i == topic_bytes.size() - 1);
	endtask

	// A byte for a plain level name: mostly a tiny alphabet, sometimes anything.
	function automatic logic [7:0] name_char();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return "a";
			4, 5, 6:    return "b";
			7:          return "c";
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Build a filter of a few levels with plain names, '+', '#' and some misplaced wildcards.
	task automatic make_filter();
		int levels;
		levels = $urandom_range(1, 4);
		filt_bytes.delete();
		if ($urandom_range(0, 7) == 0)
			filt_bytes.push_back(CH_SLASH);
		for (int lv = 0; lv < levels; lv++) begin
			if (lv > 0)
				filt_bytes.push_back(CH_SLASH);
			case ($urandom_range(0, 9))
				6, 7: filt_bytes.push_back(CH_PLUS);
				8: begin
					if (lv == levels - 1)
						filt_bytes.push_back(CH_HASH);
					else
						filt_bytes.push_back(name_char());
				end
				9: begin
					filt_bytes.push_back(name_char());
					filt_bytes.push_back($urandom_range(0, 1) ? CH_HASH : CH_PLUS);
				end
				default: begin
					repeat ($urandom_range(0, 3))
						filt_bytes.push_back(name_char());
				end
			endcase
		end
		if (filt_bytes.size() == 0)
			filt_bytes.push_back("a");
	endtask

	// A filter around the store size, to hit the overflow boundary.
	task automatic make_long_filter(input int len);
		filt_bytes.delete();
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(0, 5))
				0:       filt_bytes.push_back(CH_SLASH);
				1:       filt_bytes.push_back(CH_PLUS);
				default: filt_bytes.push_back("a");
			endcase
		end
		if ($urandom_range(0, 1))
			filt_bytes[len - 1] = CH_HASH;
	endtask

	// Derive a topic that fits the filter, then break it now and then.
	task automatic make_topic();
		logic [7:0] c;
		int         n;
		topic_bytes.delete();
		foreach (filt_bytes[i]) begin
			if (filt_bytes[i] == CH_PLUS) begin
				repeat ($urandom_range(0, 3)) begin
					c = 8'($urandom_range(0, 255));
					topic_bytes.push_back(c == CH_SLASH ? 8'("a") : c);
				end
			end else if (filt_bytes[i] == CH_HASH) begin
				repeat ($urandom_range(0, 6))
					topic_bytes.push_back($urandom_range(0, 2) == 0 ? CH_SLASH : name_char());
			end else begin
				topic_bytes.push_back(filt_bytes[i]);
			end
		end
		if (topic_bytes.size() == 0)
			topic_bytes.push_back("a");
		n = topic_bytes.size();
		case ($urandom_range(0, 9))
			0: topic_bytes[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
			1: topic_bytes[$urandom_range(0, n - 1)] = $urandom_range(0, 1) ? CH_SLASH : CH_PLUS;
			2: begin
				n = $urandom_range(1, n);
				while (topic_bytes.size() > n)
					void'(topic_bytes.pop_back());
			end
			3: begin
				topic_bytes.push_back(CH_SLASH);
				topic_bytes.push_back(name_char());
			end
			4: begin
				// Parent of a filter that ends in "/#".
				n = filt_bytes.size();
				if (n > 2 && filt_bytes[n - 1] == CH_HASH && filt_bytes[n - 2] == CH_SLASH) begin
					topic_bytes.delete();
					for (int i = 0; i < n - 2; i++)
						topic_bytes.push_back(filt_bytes[i]);
				end
			end
			default: ;
		endcase
	endtask

	// Reset, directed cases, random traffic, then the verdict.
	initial begin
		int seq;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		mode       = MODE_FILTER;
		char_in    = 8'h00;
		last_char  = 1'b0;
		quiet      = 1'b0;
		sent       = 0;
		seq        = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Topic against the empty filter left by reset.
		send_text(MODE_TOPIC, "a", 1'b1);
		// A lone '#' takes every topic.
		send_text(MODE_FILTER, "#", 1'b1);
		send_text(MODE_TOPIC, "x/y", 1'b1);
		// "a/#" also takes the parent "a".
		send_text(MODE_FILTER, "a/#", 1'b1);
		send_text(MODE_TOPIC, "a", 1'b1);
		// '+' takes an empty level.
		send_text(MODE_FILTER, "+/b", 1'b1);
		send_text(MODE_TOPIC, "/b", 1'b1);
		// Byte extremes.
		send_beat(MODE_FILTER, 8'hFF, 1'b1);
		send_beat(MODE_TOPIC, 8'h00, 1'b1);
		send_beat(MODE_FILTER, 8'h00, 1'b1);
		send_beat(MODE_TOPIC, 8'hFF, 1'b1);
		// Topic arrives while the filter is still open.
		send_text(MODE_FILTER, "a", 1'b0);
		send_text(MODE_TOPIC, "a", 1'b1);

		// Random well-formed sequences with noise and broken topics mixed in.
		while (sent < ITEM_TARGET) begin
			quiet = (sent >= 500 && sent < 750);
			seq++;
			if ($urandom_range(0, 99) < 8) begin
				repeat ($urandom_range(1, 6))
					send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
						$urandom_range(0, 3) == 0);
			end else begin
				if (seq % 25 == 7)
					make_long_filter($urandom_range(FILTER_MAX_LEN - 2, FILTER_MAX_LEN + 3));
				else
					make_filter();
				send_filter($urandom_range(0, 9) != 0);
				repeat ($urandom_range(1, 3)) begin
					make_topic();
					send_topic();
				end
			end
		end
		item_valid <= 1'b0;
		quiet = 1'b0;

		// Drain the outstanding results, then give the verdict.
		while (pending != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
